// ----- sv/icl_pkg.sv -----
package icl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Widths of the payload fields are fixed by the interface.
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int ECT_W = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [CMP_W-1:0]             t_index;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_command;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Operation broadcast to every cell of the row in the same cycle.
    typedef struct packed {
        logic   ins;
        logic   del;
        t_index pos;
        t_index key;
        t_data  value;
    } t_cell_op;

endpackage

// ----- sv/indexed_circular_list.sv -----
// Indexed list of up to CAPACITY signed words held in a row of cells.
// Input channel: a transaction is taken at a rising edge where i_start is
// high and o_busy is low. i_command selects insert (0-based slot 0..count)
// or delete (1-based entry 1..count); i_value is the word to insert.
// Output channel: one result per transaction, shown for exactly one cycle
// with o_valid high: o_removed_value, o_status and o_entry_count.
// The result is registered at the accepting edge. Every cell
// shifts toward or away from the position in the same cycle, so the
// throughput is one transaction per cycle and o_busy never rises.
// A rejected transaction (bad position, full on insert, empty on delete)
// leaves the entries and the count untouched.
// Reset clears the count and the result strobe; stored words are not
// cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result must be taken in its cycle.
module indexed_circular_list (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_command,
    input  logic [icl_pkg::POS_W-1:0] i_position,
    input  logic signed [icl_pkg::VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic signed [icl_pkg::VAL_W-1:0] o_removed_value,
    output logic [icl_pkg::STS_W-1:0] o_status,
    output logic [icl_pkg::ECT_W-1:0] o_entry_count
);
    import icl_pkg::*;

    t_count   r_count;
    t_count   n_count;
    logic     r_valid;
    t_data    r_removed;
    t_status  r_status;
    t_status  n_status;
    t_cell_op op;
    t_index   pos_ext;
    t_index   cnt_ext;
    logic     accept;
    logic     del_ok;

    t_data cell_data [CAPACITY];
    t_data chain     [CAPACITY+1];

    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign pos_ext = t_index'(i_position);
    assign cnt_ext = t_index'(r_count);

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        del_ok   = 1'b0;
        op.ins   = 1'b0;
        op.del   = 1'b0;
        op.pos   = pos_ext;
        op.key   = pos_ext - t_index'(1);
        op.value = t_data'(i_value);
        if (t_command'(i_command) == CMD_INSERT) begin
            if (pos_ext > cnt_ext) begin
                n_status = ST_RANGE;
            end else if (r_count >= t_count'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                op.ins  = accept;
                n_count = r_count + t_count'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                n_status = ST_RANGE;
            end else begin
                del_ok  = 1'b1;
                op.del  = accept;
                n_count = r_count - t_count'(1);
            end
        end
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data prev_w;
        t_data next_w;
        if (g == 0) begin : g_first
            assign prev_w = op.value;
        end else begin : g_mid
            assign prev_w = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_w = cell_data[g];
        end else begin : g_inner
            assign next_w = cell_data[g+1];
        end
        icl_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (op),
            .i_index   (t_index'(g)),
            .i_prev    (prev_w),
            .i_next    (next_w),
            .i_removed (chain[g]),
            .o_data    (cell_data[g]),
            .o_removed (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status  <= n_status;
            r_removed <= del_ok ? chain[CAPACITY] : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_removed_value = VAL_W'(r_removed);
    assign o_status        = r_status;
    assign o_entry_count   = ECT_W'(r_count);

endmodule

// ----- sv/icl_cell.sv -----
module icl_cell (
    input  logic            i_clk,
    input  icl_pkg::t_cell_op i_op,
    input  icl_pkg::t_index i_index,
    input  icl_pkg::t_data  i_prev,
    input  icl_pkg::t_data  i_next,
    input  icl_pkg::t_data  i_removed,
    output icl_pkg::t_data  o_data,
    output icl_pkg::t_data  o_removed
);
    import icl_pkg::*;

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (i_index > i_op.pos) begin
                n_data = i_prev;
            end else if (i_index == i_op.pos) begin
                n_data = i_op.value;
            end
        end else if (i_op.del) begin
            if (i_index >= i_op.key) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    // The cell at the deleted slot drops its word into the pass-along chain.
    assign o_removed = (i_index == i_op.key) ? r_data : i_removed;

endmodule

// ----- tb/list_checker.sv -----
module list_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             o_busy,
    input  logic                             i_command,
    input  logic [icl_pkg::POS_W-1:0]        i_position,
    input  logic signed [icl_pkg::VAL_W-1:0] i_value,
    input  logic                             o_valid,
    input  logic signed [icl_pkg::VAL_W-1:0] o_removed_value,
    input  logic [icl_pkg::STS_W-1:0]        o_status,
    input  logic [icl_pkg::ECT_W-1:0]        o_entry_count,
    output int                               o_fail_count,
    output int                               o_pending
);
    import icl_pkg::*;

    typedef struct {
        t_data            removed;
        t_status          status;
        logic [ECT_W-1:0] count;
    } t_list_result;

    t_data        stored_words [CAPACITY];
    int unsigned  stored_count;
    t_list_result result_queue [$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Applies one insert or delete to the shadow list and returns the
    // result that the block has to show for it.
    function automatic t_list_result apply_list_op(input t_command cmd,
                                                   input int unsigned pos,
                                                   input t_data val);
        t_list_result r;
        int unsigned  i;
        r.removed = '0;
        r.status  = ST_OK;
        if (cmd == CMD_INSERT) begin
            // The range check takes priority over the full check.
            if (pos > stored_count) begin
                r.status = ST_RANGE;
            end else if (stored_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (i = stored_count; i > pos; i--) begin
                    stored_words[i] = stored_words[i-1];
                end
                stored_words[pos] = val;
                stored_count++;
            end
        end else begin
            if (stored_count == 0) begin
                r.status = ST_EMPTY;
            end else if (pos == 0 || pos > stored_count) begin
                r.status = ST_RANGE;
            end else begin
                r.removed = stored_words[pos-1];
                for (i = pos - 1; i + 1 < stored_count; i++) begin
                    stored_words[i] = stored_words[i+1];
                end
                stored_count--;
            end
        end
        r.count = ECT_W'(stored_count);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            stored_count = 0;
            result_queue.delete();
        end else begin
            // The result of the previous transaction is checked before the
            // transaction taken at this edge is predicted.
            if (o_valid === 1'b1) begin
                if (result_queue.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = result_queue.pop_front();
                    if (o_removed_value !== want.removed) begin
                        report_mismatch($sformatf("removed_value expected %0d got %0d",
                                                  want.removed, o_removed_value));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status expected %s got %0d",
                                                  want.status.name(), o_status));
                    end
                    if (o_entry_count !== want.count) begin
                        report_mismatch($sformatf("entry_count expected %0d got %0d",
                                                  want.count, o_entry_count));
                    end
                end
            end
            if (i_start && !o_busy) begin
                result_queue.push_back(apply_list_op(t_command'(i_command),
                                                     i_position, i_value));
            end
        end
        o_pending = result_queue.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import icl_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 200;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_start    = 1'b0;
    logic                    i_command  = CMD_INSERT;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_removed_value;
    logic [STS_W-1:0]        o_status;
    logic [ECT_W-1:0]        o_entry_count;

    int fail_count;
    int pending;
    int stall_cycles = 0;

    // Occupancy as seen by the stimulus, used to steer positions and to tally outcomes.
    int unsigned list_len = 0;
    int n_items = 0;
    int n_inserted = 0;
    int n_deleted = 0;
    int n_range = 0;
    int n_full = 0;
    int n_empty = 0;

    always #1 i_clk = ~i_clk;

    indexed_circular_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

    list_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Called just after a rising edge; returns once the block has taken the
    // transaction.
    task automatic send_op(input t_command cmd, input int unsigned pos, input t_data val);
        i_start    <= 1'b1;
        i_command  <= cmd;
        i_position <= pos[POS_W-1:0];
        i_value    <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        n_items++;
        if (cmd == CMD_INSERT) begin
            if (pos > list_len) n_range++;
            else if (list_len >= CAPACITY) n_full++;
            else begin
                list_len++;
                n_inserted++;
            end
        end else begin
            if (list_len == 0) n_empty++;
            else if (pos == 0 || pos > list_len) n_range++;
            else begin
                list_len--;
                n_deleted++;
            end
        end
    endtask

    // Each cycle is idle with the given chance, so that share of cycles is idle.
    task automatic maybe_idle(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int          phase;
        int          n;
        int          idle_pct;
        int          run_left;
        bit          filling;
        t_command    cmd;
        int unsigned pos;
        t_data       val;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty list, range errors, extreme values, both ends.
        send_op(CMD_DELETE, 0, 0);
        send_op(CMD_DELETE, 31, 0);
        send_op(CMD_INSERT, 1, 5);
        send_op(CMD_INSERT, 31, 5);
        send_op(CMD_INSERT, 0, 32'sh7fffffff);
        send_op(CMD_INSERT, 1, 32'sh80000000);
        send_op(CMD_INSERT, 1, -1);
        send_op(CMD_INSERT, 0, 0);
        send_op(CMD_DELETE, 0, 0);
        send_op(CMD_DELETE, 5, 0);
        send_op(CMD_DELETE, 4, 0);
        send_op(CMD_DELETE, 1, 0);
        while (list_len < CAPACITY) begin
            send_op(CMD_INSERT, $urandom_range(0, list_len), $urandom);
        end
        // At full, a valid slot reports full while one past the end is a range error.
        send_op(CMD_INSERT, CAPACITY, 1);
        send_op(CMD_INSERT, CAPACITY + 1, 1);
        send_op(CMD_INSERT, 0, 1);
        send_op(CMD_DELETE, CAPACITY, 0);
        send_op(CMD_DELETE, 8, 0);

        // Random part: bursts that lean toward filling or draining the list so
        // that both the full and the empty ends are visited repeatedly.
        run_left = 0;
        filling  = 1'b0;
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 23 : (phase == 1) ? 75 : 0;
            for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(10, 60);
                    filling  = ~filling;
                end
                run_left--;
                if ($urandom_range(0, 99) < 80) cmd = filling ? CMD_INSERT : CMD_DELETE;
                else cmd = filling ? CMD_DELETE : CMD_INSERT;
                if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 31);
                else if (cmd == CMD_INSERT) pos = $urandom_range(0, list_len);
                else if (list_len == 0) pos = $urandom_range(0, 31);
                else pos = $urandom_range(1, list_len);
                case ($urandom_range(0, 19))
                    0:       val = 32'sh7fffffff;
                    1:       val = 32'sh80000000;
                    2:       val = -1;
                    3:       val = 0;
                    default: val = $urandom;
                endcase
                maybe_idle(idle_pct);
                send_op(cmd, pos, val);
            end
        end
        i_start <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("%0d transactions: %0d inserts and %0d deletes done, %0d out of range,",
                 n_items, n_inserted, n_deleted, n_range);
        $display("%0d rejected as full and %0d as empty, sender idle 23/75/0 percent by phase",
                 n_full, n_empty);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- indexed_circular_list.f -----
sv/icl_pkg.sv
sv/icl_cell.sv
sv/indexed_circular_list.sv
tb/list_checker.sv
tb/tb_top.sv
